[hw/rtl/tieu_pkg.sv]
package tieu_pkg;

   localparam int NUM_REGS    = 32;
   localparam int MEM_NIBBLES = 4096;

   localparam int RF_AW      = $clog2(NUM_REGS);
   localparam int MEM_AW     = $clog2(MEM_NIBBLES);
   localparam int CLR_W      = MEM_AW + 1;
   localparam int OP_W       = 4;
   localparam int REG_IDX_W  = 5;
   localparam int DATA_W     = 32;
   localparam int ADDR_W     = 12;
   localparam int NIB_SUM_W  = ADDR_W + 1;
   localparam int NIB_W      = 4;

   localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
   localparam logic [OP_W-1:0] OP_ADDI = 4'd2;
   localparam logic [OP_W-1:0] OP_SUBI = 4'd3;
   localparam logic [OP_W-1:0] OP_MULI = 4'd4;
   localparam logic [OP_W-1:0] OP_LW   = 4'd5;
   localparam logic [OP_W-1:0] OP_SW   = 4'd6;
   localparam logic [OP_W-1:0] OP_BNE  = 4'd7;
   localparam logic [OP_W-1:0] OP_BEQ  = 4'd8;
   localparam logic [OP_W-1:0] OP_SGT  = 4'd9;
   localparam logic [OP_W-1:0] OP_JUMP = 4'd10;

   // register file read port select
   localparam logic [1:0] RD_SRC    = 2'd0;
   localparam logic [1:0] RD_SECOND = 2'd1;
   localparam logic [1:0] RD_R16    = 2'd2;

   // SGT loads its destination from this register
   localparam logic [REG_IDX_W-1:0] SGT_SRC_IDX = 5'd16;

   typedef struct packed {
      logic       latch;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       cap_vb;
      logic       exec;
      logic       sgt_wr;
      logic       cap_r16;
      logic       mem_en;
      logic [1:0] mem_idx;
      logic       finish;
   } tieu_cmd_type;

   typedef struct packed {
      logic            clear_done;
      logic [OP_W-1:0] op;
      logic            sgt_ge;
      logic            out_free;
   } tieu_status_type;

endpackage

[hw/rtl/tieu_ctrl.sv]
module tieu_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tieu_pkg::tieu_status_type status,
   output tieu_pkg::tieu_cmd_type    cmd
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_RB     = 4'd2;
   localparam logic [3:0] S_RX     = 4'd3;
   localparam logic [3:0] S_EXEC   = 4'd4;
   localparam logic [3:0] S_MEM    = 4'd5;
   localparam logic [3:0] S_MEMEND = 4'd6;
   localparam logic [3:0] S_R16    = 4'd7;
   localparam logic [3:0] S_R16D   = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [1:0] k_ff, k_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            if (status.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.latch = req_valid;
            if (req_valid) state_in = S_RB;
         end
         S_RB: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = tieu_pkg::RD_SRC;
            state_in   = S_RX;
         end
         S_RX: begin
            cmd.cap_vb = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = tieu_pkg::RD_SECOND;
            state_in   = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            k_in     = 2'd0;
            priority if (status.op == tieu_pkg::OP_SGT && status.sgt_ge) begin
               cmd.sgt_wr = 1'b1;
               state_in   = S_R16;
            end else if (status.op == tieu_pkg::OP_LW || status.op == tieu_pkg::OP_SW) begin
               state_in = S_MEM;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MEM: begin
            cmd.mem_en  = 1'b1;
            cmd.mem_idx = k_ff;
            k_in        = k_ff + 2'd1;
            if (k_ff == 2'd3) state_in = S_MEMEND;
         end
         // last load nibble shifts in here
         S_MEMEND: begin
            state_in = S_DONE;
         end
         S_R16: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = tieu_pkg::RD_R16;
            state_in   = S_R16D;
         end
         S_R16D: begin
            cmd.cap_r16 = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         k_ff     <= 2'd0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

endmodule

[hw/rtl/tieu_datapath.sv]
module tieu_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  tieu_pkg::tieu_cmd_type                  cmd,
   output tieu_pkg::tieu_status_type               status,
   input  logic [tieu_pkg::OP_W-1:0]               req_cmd,
   input  logic [tieu_pkg::REG_IDX_W-1:0]          req_dest_reg,
   input  logic [tieu_pkg::REG_IDX_W-1:0]          req_src_reg,
   input  logic [tieu_pkg::REG_IDX_W-1:0]          req_third_reg,
   input  logic signed [tieu_pkg::DATA_W-1:0]      req_immediate,
   input  logic [tieu_pkg::ADDR_W-1:0]             req_mem_addr,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_branch_taken,
   output logic                                    rsp_reg_written,
   output logic signed [tieu_pkg::DATA_W-1:0]      rsp_result_value
);

   // latched transaction
   logic [tieu_pkg::OP_W-1:0]      op_ff;
   logic [tieu_pkg::REG_IDX_W-1:0] ra_ff, rb_ff, rc_ff;
   logic [tieu_pkg::DATA_W-1:0]    imm_ff;
   logic [tieu_pkg::ADDR_W-1:0]    addr_ff;

   logic [tieu_pkg::DATA_W-1:0]    vb_ff;
   logic [tieu_pkg::DATA_W-1:0]    value_ff, value_in;
   logic                           taken_ff, taken_in;
   logic                           written_ff, written_in;

   // register file
   logic [tieu_pkg::DATA_W-1:0]    rf_mem [tieu_pkg::NUM_REGS];
   logic [tieu_pkg::NUM_REGS-1:0]  rf_valid_ff;
   logic [tieu_pkg::DATA_W-1:0]    rf_rdata_ff;
   logic                           rf_rhit_ff;
   logic [tieu_pkg::REG_IDX_W-1:0] rf_rd_reg;
   logic                           rf_rd_ok;
   logic [tieu_pkg::DATA_W-1:0]    rf_rd_data;
   logic [tieu_pkg::REG_IDX_W-1:0] rf_wr_reg;
   logic [tieu_pkg::DATA_W-1:0]    rf_wdata;
   logic                           rf_we;

   // nibble memory
   logic [tieu_pkg::NIB_W-1:0]     nib_mem [tieu_pkg::MEM_NIBBLES];
   logic [tieu_pkg::NIB_W-1:0]     nib_rdata_ff;
   logic                           nib_rhit_ff;
   logic                           nib_shift_ff;
   logic [tieu_pkg::NIB_SUM_W-1:0] nib_sum;
   logic                           nib_ok;
   logic                           nib_rd_en;
   logic                           nib_we;
   logic [tieu_pkg::MEM_AW-1:0]    nib_widx;
   logic [tieu_pkg::NIB_W-1:0]     nib_wdata;
   logic [tieu_pkg::NIB_W-1:0]     sw_nib;
   logic [tieu_pkg::CLR_W-1:0]     clr_cnt_ff;
   logic                           clear_done;

   logic [tieu_pkg::DATA_W-1:0]    alu_out;

   logic                           out_valid_ff;
   logic                           out_taken_ff;
   logic                           out_written_ff;
   logic [tieu_pkg::DATA_W-1:0]    out_value_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= req_cmd;
         ra_ff   <= req_dest_reg;
         rb_ff   <= req_src_reg;
         rc_ff   <= req_third_reg;
         imm_ff  <= req_immediate;
         addr_ff <= req_mem_addr;
      end
      if (cmd.cap_vb) vb_ff <= rf_rd_data;
   end

   // ---------------- register file ----------------
   always_comb begin
      unique case (cmd.rd_sel)
         tieu_pkg::RD_SRC:    rf_rd_reg = rb_ff;
         tieu_pkg::RD_SECOND: rf_rd_reg = (op_ff == tieu_pkg::OP_BNE ||
                                           op_ff == tieu_pkg::OP_BEQ) ? ra_ff : rc_ff;
         tieu_pkg::RD_R16:    rf_rd_reg = tieu_pkg::SGT_SRC_IDX;
         default:             rf_rd_reg = rb_ff;
      endcase
   end

   assign rf_rd_ok   = (32'(rf_rd_reg) < 32'(tieu_pkg::NUM_REGS));
   assign rf_rd_data = rf_rhit_ff ? rf_rdata_ff : '0;

   // SGT writes rc first; the destination write happens when the result retires
   always_comb begin
      if (cmd.sgt_wr) begin
         rf_wr_reg = rc_ff;
         rf_wdata  = vb_ff;
      end else begin
         rf_wr_reg = ra_ff;
         rf_wdata  = value_ff;
      end
   end

   assign rf_we = (cmd.sgt_wr || (cmd.finish && written_ff)) &&
                  (32'(rf_wr_reg) < 32'(tieu_pkg::NUM_REGS));

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rf_rdata_ff <= rf_mem[tieu_pkg::RF_AW'(rf_rd_reg)];
         rf_rhit_ff  <= rf_rd_ok && rf_valid_ff[tieu_pkg::RF_AW'(rf_rd_reg)];
      end
      if (rf_we) rf_mem[tieu_pkg::RF_AW'(rf_wr_reg)] <= rf_wdata;
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
      end else if (rf_we) begin
         rf_valid_ff[tieu_pkg::RF_AW'(rf_wr_reg)] <= 1'b1;
      end
   end

   // ---------------- execute ----------------
   always_comb begin
      unique case (op_ff)
         tieu_pkg::OP_ADD:  alu_out = vb_ff + rf_rd_data;
         tieu_pkg::OP_SUB:  alu_out = vb_ff - rf_rd_data;
         tieu_pkg::OP_ADDI: alu_out = vb_ff + imm_ff;
         tieu_pkg::OP_SUBI: alu_out = vb_ff - imm_ff;
         tieu_pkg::OP_MULI: alu_out = vb_ff * imm_ff;
         default:           alu_out = '0;
      endcase
   end

   always_comb begin
      value_in   = value_ff;
      taken_in   = taken_ff;
      written_in = written_ff;
      priority if (cmd.exec) begin
         value_in   = '0;
         taken_in   = 1'b0;
         written_in = 1'b0;
         unique case (op_ff)
            tieu_pkg::OP_ADD, tieu_pkg::OP_SUB, tieu_pkg::OP_ADDI,
            tieu_pkg::OP_SUBI, tieu_pkg::OP_MULI: begin
               value_in   = alu_out;
               written_in = 1'b1;
            end
            tieu_pkg::OP_LW:   written_in = 1'b1;
            tieu_pkg::OP_BNE:  taken_in   = (vb_ff != rf_rd_data);
            tieu_pkg::OP_BEQ:  taken_in   = (vb_ff == rf_rd_data);
            tieu_pkg::OP_SGT:  written_in = status.sgt_ge;
            tieu_pkg::OP_JUMP: taken_in   = 1'b1;
            default: begin
            end
         endcase
      end else if (cmd.cap_r16) begin
         value_in = rf_rd_data;
      end else if (nib_shift_ff) begin
         value_in = {value_ff[tieu_pkg::DATA_W-tieu_pkg::NIB_W-1:0],
                     nib_rhit_ff ? nib_rdata_ff : 4'h0};
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      taken_ff   <= taken_in;
      written_ff <= written_in;
   end

   // ---------------- nibble memory ----------------
   assign nib_sum    = {1'b0, addr_ff} + tieu_pkg::NIB_SUM_W'(cmd.mem_idx);
   assign nib_ok     = (32'(nib_sum) < 32'(tieu_pkg::MEM_NIBBLES));
   assign nib_rd_en  = cmd.mem_en && (op_ff == tieu_pkg::OP_LW);
   // digit k of the store is bits 15-4k downto 12-4k
   assign sw_nib     = tieu_pkg::NIB_W'(vb_ff[15:0] >> {~cmd.mem_idx, 2'b00});
   assign clear_done = (clr_cnt_ff == tieu_pkg::CLR_W'(tieu_pkg::MEM_NIBBLES));

   always_comb begin
      if (!clear_done) begin
         nib_we    = 1'b1;
         nib_widx  = tieu_pkg::MEM_AW'(clr_cnt_ff);
         nib_wdata = '0;
      end else begin
         nib_we    = cmd.mem_en && (op_ff == tieu_pkg::OP_SW) && nib_ok;
         nib_widx  = tieu_pkg::MEM_AW'(nib_sum);
         nib_wdata = sw_nib;
      end
   end

   always_ff @(posedge clock) begin
      if (nib_rd_en) begin
         nib_rdata_ff <= nib_mem[tieu_pkg::MEM_AW'(nib_sum)];
         nib_rhit_ff  <= nib_ok;
      end
      if (nib_we) nib_mem[nib_widx] <= nib_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         nib_shift_ff <= 1'b0;
      end else begin
         if (!clear_done) clr_cnt_ff <= clr_cnt_ff + tieu_pkg::CLR_W'(1);
         nib_shift_ff <= nib_rd_en;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_taken_ff   <= taken_ff;
         out_written_ff <= written_ff;
         out_value_ff   <= written_ff ? value_ff : '0;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_branch_taken = out_taken_ff;
   assign rsp_reg_written  = out_written_ff;
   assign rsp_result_value = out_value_ff;

   assign status.clear_done = clear_done;
   assign status.op         = op_ff;
   assign status.sgt_ge     = ($signed(vb_ff) >= $signed(rf_rd_data));
   assign status.out_free   = !out_valid_ff || !rsp_stall;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!out_valid_ff || !rsp_stall))
      else $error("result register overwritten while held");

   a_no_access_in_clear: assert property (@(posedge clock) disable iff (reset)
      !clear_done |-> (!cmd.mem_en && !cmd.latch))
      else $error("memory access during clearing pass");

   a_zero_when_unwritten: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_written_ff) |-> (out_value_ff == '0))
      else $error("nonzero value without register write");

   a_taken_excl_written: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_taken_ff && out_written_ff))
      else $error("branch taken and register written together");
`endif

endmodule

[hw/rtl/toy_isa_execute_unit_top.sv]
// Channel   Ports                                          Direction
// req       req_valid/req_stall, req_cmd .. req_mem_addr   in  (stall driven out)
// rsp       rsp_valid/rsp_stall, rsp_branch_taken ..       out (stall driven in)
//
// One transaction at a time. ADD/SUB/ADDI/SUBI/MULI/BNE/BEQ/JUMP: two register reads,
// execute, result load; SGT with condition true adds an rc write and an R16 read;
// LW/SW add one nibble per cycle through the single memory port. Register reads are
// one per cycle. After reset the nibble memory is cleared one entry a cycle, req_stall
// high. A new request is taken while a result waits under rsp_stall.
module toy_isa_execute_unit_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [tieu_pkg::OP_W-1:0]          req_cmd,
   input  logic [tieu_pkg::REG_IDX_W-1:0]     req_dest_reg,
   input  logic [tieu_pkg::REG_IDX_W-1:0]     req_src_reg,
   input  logic [tieu_pkg::REG_IDX_W-1:0]     req_third_reg,
   input  logic signed [tieu_pkg::DATA_W-1:0] req_immediate,
   input  logic [tieu_pkg::ADDR_W-1:0]        req_mem_addr,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_branch_taken,
   output logic                               rsp_reg_written,
   output logic signed [tieu_pkg::DATA_W-1:0] rsp_result_value
);

   tieu_pkg::tieu_cmd_type    cmd;
   tieu_pkg::tieu_status_type status;

   tieu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tieu_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_cmd          (req_cmd),
      .req_dest_reg     (req_dest_reg),
      .req_src_reg      (req_src_reg),
      .req_third_reg    (req_third_reg),
      .req_immediate    (req_immediate),
      .req_mem_addr     (req_mem_addr),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_branch_taken (rsp_branch_taken),
      .rsp_reg_written  (rsp_reg_written),
      .rsp_result_value (rsp_result_value)
   );

endmodule
